@@ hw/rtl/tdwq_pkg.sv @@
// tdwq_pkg: shared types and constants of the tick delay wake-up queue
// used by tdwq_cell, tdwq_chain and tick_delay_wakeup_queue; no dependencies
`timescale 1ns / 1ps

package tdwq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned TASK_W = 8;

	// input opcodes
	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_QUERY     = 2'd1,
		OP_DELAY_REL = 2'd2,
		OP_DELAY_ABS = 2'd3
	} op_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_TIME  = 2'd1,
		KIND_WOKEN = 2'd2,
		KIND_FULL  = 2'd3
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP,
		ST_DRAIN
	} state_t;

	// one queue slot
	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] wake_time;
		logic [TASK_W-1:0] tid;
	} entry_t;

	// commands broadcast to every cell
	typedef struct packed {
		logic insert;
		logic pop;
	} chain_ctrl_t;

endpackage

@@ hw/rtl/tdwq_cell.sv @@
// tdwq_cell: one slot of the sorted wake-up chain
// depends on tdwq_pkg
`timescale 1ns / 1ps

module tdwq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdwq_pkg::chain_ctrl_t       ctrl,
	input  tdwq_pkg::entry_t            new_entry,
	input  tdwq_pkg::entry_t            left_entry,
	input  logic                        left_keeps,
	input  tdwq_pkg::entry_t            right_entry,
	input  logic [tdwq_pkg::TIME_W-1:0] count,
	output tdwq_pkg::entry_t            cur_entry,
	output logic                        keeps,
	output logic                        due
);

	logic                        valid_q;
	logic [tdwq_pkg::TIME_W-1:0] time_q;
	logic [tdwq_pkg::TASK_W-1:0] tid_q;
	tdwq_pkg::entry_t            nxt;

	assign cur_entry = '{valid: valid_q, wake_time: time_q, tid: tid_q};

	// this slot stays put on insert when it wakes no later than the new entry
	assign keeps = valid_q && (time_q <= new_entry.wake_time);
	assign due   = valid_q && (time_q <= count);

	// insert: keep, take the new entry, or shift right; pop: shift left
	always_comb begin
		nxt = cur_entry;
		if (ctrl.insert) begin
			if (!keeps) begin
				nxt = left_keeps ? new_entry : left_entry;
			end
		end else if (ctrl.pop) begin
			nxt = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		time_q <= nxt.wake_time;
		tid_q  <= nxt.tid;
	end

endmodule

@@ hw/rtl/tdwq_chain.sv @@
// tdwq_chain: row of tdwq_cell slots kept sorted by wake time, head first
// depends on tdwq_pkg and tdwq_cell
`timescale 1ns / 1ps

module tdwq_chain #(
	parameter int unsigned QUEUE_DEPTH = tdwq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tdwq_pkg::chain_ctrl_t       ctrl,
	input  tdwq_pkg::entry_t            new_entry,
	input  logic [tdwq_pkg::TIME_W-1:0] count,
	output tdwq_pkg::entry_t            head_entry,
	output logic                        head_due,
	output logic                        next_due,
	output logic                        full
);

	tdwq_pkg::entry_t cells   [QUEUE_DEPTH];
	logic             keep_v  [QUEUE_DEPTH];
	logic             due_v   [QUEUE_DEPTH];

	// neighbors: the head sees an always-keeping edge, the tail an empty slot
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tdwq_pkg::entry_t left_e;
		tdwq_pkg::entry_t right_e;
		logic             left_k;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_k = 1'b1;
		end else begin : g_body
			assign left_e = cells[i-1];
			assign left_k = keep_v[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = cells[i+1];
		end

		tdwq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_entry (left_e),
			.left_keeps (left_k),
			.right_entry(right_e),
			.count      (count),
			.cur_entry  (cells[i]),
			.keeps      (keep_v[i]),
			.due        (due_v[i])
		);
	end

	assign head_entry = cells[0];
	assign head_due   = due_v[0];
	assign full       = cells[QUEUE_DEPTH-1].valid;

	// due flag of the slot that becomes head after a pop
	if (QUEUE_DEPTH > 1) begin : g_next
		assign next_due = due_v[1];
	end else begin : g_single
		assign next_due = 1'b0;
	end

endmodule

@@ hw/rtl/tick_delay_wakeup_queue.sv @@
// tick_delay_wakeup_queue: tick counter with a sorted wake-up queue of tasks
// depends on tdwq_pkg and tdwq_chain
`timescale 1ns / 1ps

// Input channel (in_valid/in_ready) carries opcode, task_id and time_arg:
// tick, time query, relative delay or absolute delay. Output channel
// (out_valid/out_ready) carries kind, target_task, tick_value and last, one
// beat per result; last marks the final result of an input beat.
// A tick gives an acknowledge beat, a query a time reply, a delay that finds
// the queue full a reject beat; then every queued task whose wake time is at
// or below the count is released as a woken beat, earliest first, equal wake
// times in arrival order. A delay that releases nothing gives no beat.
// One input beat at a time: a delay that releases nothing is accepted, then
// inserted into the cell chain; with results, the result beats follow, the
// output register being loaded once a cycle while the receiver is ready. The
// chain pops its head once a cycle under the same condition. Every kind of
// input beat goes through ST_EXEC before its first result is loaded.
// Reset clears the count, empties the queue and drops any pending beat.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits; in_ready stays low until all results of a beat are loaded.
module tick_delay_wakeup_queue #(
	parameter int unsigned QUEUE_DEPTH = tdwq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  opcode,
	input  logic [tdwq_pkg::TASK_W-1:0] task_id,
	input  logic [tdwq_pkg::TIME_W-1:0] time_arg,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [tdwq_pkg::TASK_W-1:0] target_task,
	output logic [tdwq_pkg::TIME_W-1:0] tick_value,
	output logic                        last
);

	tdwq_pkg::state_t            state_q, state_d;
	tdwq_pkg::op_t               op_q;
	logic [tdwq_pkg::TASK_W-1:0] task_q;
	logic [tdwq_pkg::TIME_W-1:0] tv_q;
	logic [tdwq_pkg::TIME_W-1:0] count_q;
	tdwq_pkg::kind_t             pend_kind_q, pend_kind_d;

	logic                        out_valid_q;
	tdwq_pkg::kind_t             out_kind_q;
	logic [tdwq_pkg::TASK_W-1:0] out_task_q;
	logic [tdwq_pkg::TIME_W-1:0] out_tick_q;
	logic                        out_last_q;

	tdwq_pkg::chain_ctrl_t       ctrl;
	tdwq_pkg::entry_t            new_entry;
	tdwq_pkg::entry_t            head_entry;
	logic                        head_due;
	logic                        next_due;
	logic                        full;
	logic [tdwq_pkg::TIME_W-1:0] wake_time;

	logic                        in_beat;
	logic                        slot_free;
	logic                        load;
	tdwq_pkg::kind_t             load_kind;
	logic [tdwq_pkg::TASK_W-1:0] load_task;
	logic                        load_last;
	logic                        count_inc;

	assign in_ready  = (state_q == tdwq_pkg::ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// wake time of a delay request
	assign wake_time = (op_q == tdwq_pkg::OP_DELAY_REL) ? count_q + tv_q : tv_q;
	assign new_entry = '{valid: 1'b1, wake_time: wake_time, tid: task_q};

	tdwq_chain #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.new_entry (new_entry),
		.count     (count_q),
		.head_entry(head_entry),
		.head_due  (head_due),
		.next_due  (next_due),
		.full      (full)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdwq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, chain commands and output loads
	always_comb begin
		state_d     = state_q;
		pend_kind_d = pend_kind_q;
		ctrl        = '0;
		count_inc   = 1'b0;
		load        = 1'b0;
		load_kind   = tdwq_pkg::KIND_WOKEN;
		load_task   = head_entry.tid;
		load_last   = 1'b1;
		unique case (state_q)
			tdwq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tdwq_pkg::ST_EXEC;
				end
			end
			tdwq_pkg::ST_EXEC: begin
				unique case (op_q)
					tdwq_pkg::OP_TICK: begin
						count_inc   = 1'b1;
						pend_kind_d = tdwq_pkg::KIND_ACK;
						state_d     = tdwq_pkg::ST_RESP;
					end
					tdwq_pkg::OP_QUERY: begin
						pend_kind_d = tdwq_pkg::KIND_TIME;
						state_d     = tdwq_pkg::ST_RESP;
					end
					default: begin
						if (full) begin
							pend_kind_d = tdwq_pkg::KIND_FULL;
							state_d     = tdwq_pkg::ST_RESP;
						end else begin
							ctrl.insert = 1'b1;
							state_d     = (wake_time <= count_q) ? tdwq_pkg::ST_DRAIN
							                                     : tdwq_pkg::ST_IDLE;
						end
					end
				endcase
			end
			tdwq_pkg::ST_RESP: begin
				if (slot_free) begin
					load      = 1'b1;
					load_kind = pend_kind_q;
					load_task = task_q;
					load_last = !head_due;
					state_d   = head_due ? tdwq_pkg::ST_DRAIN : tdwq_pkg::ST_IDLE;
				end
			end
			tdwq_pkg::ST_DRAIN: begin
				if (!head_due) begin
					state_d = tdwq_pkg::ST_IDLE;
				end else if (slot_free) begin
					load      = 1'b1;
					load_last = !next_due;
					ctrl.pop  = 1'b1;
					state_d   = next_due ? tdwq_pkg::ST_DRAIN : tdwq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tdwq_pkg::ST_IDLE;
			end
		endcase
	end

	// tick count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (count_inc) begin
			count_q <= count_q + 1'b1;
		end
	end

	// captured input beat and pending result kind
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q   <= tdwq_pkg::op_t'(opcode);
			task_q <= task_id;
			tv_q   <= time_arg;
		end
		pend_kind_q <= pend_kind_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= load_kind;
			out_task_q <= load_task;
			out_tick_q <= count_q;
			out_last_q <= load_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = out_kind_q;
	assign target_task = out_task_q;
	assign tick_value  = out_tick_q;
	assign last        = out_last_q;

`ifndef SYNTHESIS
	// nothing is left due once the sequencer is back at rest
	a_idle_nothing_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdwq_pkg::ST_IDLE) |-> !head_due)
		else $error("due entry left in queue while idle");

	// pops only take a due head
	a_pop_due: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> head_due)
		else $error("pop of an entry that is not due");

	// inserts never overflow the chain
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.insert |-> !full)
		else $error("insert into a full queue");

	// a woken beat carries the head task that was popped
	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> (out_valid_q && out_kind_q == tdwq_pkg::KIND_WOKEN
		              && out_task_q == $past(head_entry.tid)))
		else $error("popped task not presented as woken beat");
`endif

endmodule
